### rtl/dlsc_pkg.sv
// ---------------------------------------------------------------------------
// dlsc_pkg
// Shared types, codes and helper functions for the delay-line sensor
// calibrator: item and result words, the queued command and the delay coding.
// ---------------------------------------------------------------------------
`default_nettype none

package dlsc_pkg;

  // delay line geometry
  localparam int COARSE_BITS = 32;
  localparam int FINE_BITS   = 96;
  localparam int SAMPLE_BITS = 16;

  localparam int NUM_WORDS  = (COARSE_BITS + FINE_BITS) / 32;
  localparam int FINE_WORDS = FINE_BITS / 32;

  localparam logic [5:0]  COARSE_MAX = 6'(COARSE_BITS);
  localparam logic [6:0]  FINE_MAX   = 7'(FINE_BITS);
  localparam logic [10:0] COUNT_MAX  = 11'h7ff;
  localparam logic [15:0] SAMPLE_MASK = 16'(17'((1 << SAMPLE_BITS) - 1));
  localparam logic [15:0] SAMPLE_MSB  = 16'(17'(1 << (SAMPLE_BITS - 1)));

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // result kinds
  localparam logic [1:0] KIND_CLASS  = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // sample classes
  localparam logic [2:0] CLS_ZEROS   = 3'd0;
  localparam logic [2:0] CLS_ONES    = 3'd1;
  localparam logic [2:0] CLS_RISING  = 3'd2;
  localparam logic [2:0] CLS_FALLING = 3'd3;
  localparam logic [2:0] CLS_ERROR   = 3'd4;

  // input functions
  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_VERDICT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] sensor_pair_word;
    logic        last_sample;
    logic        accept;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  sample_class;
    logic [4:0]  sample_weight;
    logic [31:0] delay_word;
    logic [1:0]  word_index;
    logic [5:0]  coarse_delay;
    logic [6:0]  fine_delay;
    logic        found;
    logic        exhausted;
    logic        calibrated;
    logic        last;
  } out_word_t;

  // result sequence an item asks for
  typedef enum logic [2:0] {
    OP_CLASS        = 3'd0,  // classification only
    OP_CLASS_WORDS  = 3'd1,  // classification, then all delay words
    OP_CLASS_STATUS = 3'd2,  // classification, then status
    OP_STATUS       = 3'd3,  // status only
    OP_WORDS        = 3'd4   // all delay words
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] sample_class;
    logic [4:0] sample_weight;
    logic [5:0] coarse_delay;
    logic [6:0] fine_delay;
    logic       found;
    logic       exhausted;
    logic       calibrated;
  } cmd_t;

  // one 32-bit word of a thermometer code of value val, word w
  function automatic logic [31:0] therm_word(input logic [8:0] val, input logic [1:0] w);
    logic [8:0] base;
    logic [8:0] cnt;
    base = {2'b00, w, 5'b00000};
    cnt  = val - base;
    if (val <= base) begin
      return 32'h0000_0000;
    end else if (cnt >= 9'd32) begin
      return 32'hffff_ffff;
    end else begin
      return ~(32'hffff_ffff >> cnt[4:0]);
    end
  endfunction

  // delay register chunk c, chunk 0 being the top word (coarse side)
  function automatic logic [31:0] delay_chunk(input logic [5:0] coarse,
                                              input logic [6:0] fine,
                                              input logic [1:0] c);
    logic [1:0] w;
    w = 2'(NUM_WORDS - 1) - c;
    if (w < 2'(FINE_WORDS)) begin
      return therm_word({2'b00, fine}, w);
    end else begin
      return therm_word({3'b000, coarse}, w - 2'(FINE_WORDS));
    end
  endfunction

endpackage

`default_nettype wire

### rtl/delay_line_sensor_calibrator.sv
// The first result word of an item goes through the command queue and then the
// output register before it is on the result ports, where it waits until popped.
// Throughput: one item accepted per cycle while the 4-entry command queue has
// room; an item makes 1 to 5 result words, one per cycle while the receiver pops.
// Sustained rate is set by the result port: items with one word flow 1/cycle.
// Reset (rst, synchronous): clears delays, counters, flags, sensor index,
// the command queue and the output valid flag; ready the cycle after.
// ---------------------------------------------------------------------------
// delay_line_sensor_calibrator
// Delay-line sensor initial-delay calibration: front classifies and steps,
// queue decouples, back streams result words.
// ---------------------------------------------------------------------------
`default_nettype none

module delay_line_sensor_calibrator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire dlsc_pkg::in_word_t item,
  output logic                    empty,
  input  wire logic               pop,
  output dlsc_pkg::out_word_t     result
);
  import dlsc_pkg::*;

  cmd_t cmd;
  cmd_t head;
  logic take;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign full = q_full;
  assign take = push && !q_full;

  // front: classify and update state
  dlsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .take     (take),
    .item     (item),
    .cmd      (cmd)
  );

  // command queue
  dlsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_cmd  (cmd),
    .rd_en   (q_pop),
    .head    (head),
    .q_full  (q_full),
    .q_valid (q_valid)
  );

  // back: expand commands into result words
  dlsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

### rtl/dlsc_front.sv
// ---------------------------------------------------------------------------
// dlsc_front
// Accepts items, classifies samples, keeps the calibration state and issues
// one command per item into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module dlsc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [4:0]        cfg_data,
  input  wire logic              take,
  input  wire dlsc_pkg::in_word_t item,
  output dlsc_pkg::cmd_t         cmd
);
  import dlsc_pkg::*;

  logic [4:0]  sensor_index;
  logic [5:0]  coarse;
  logic [6:0]  fine;
  logic [10:0] nonzero_count;
  logic        locked;
  logic        done;

  logic [5:0]  coarse_next;
  logic [6:0]  fine_next;
  logic [10:0] count_next;
  logic        locked_next;
  logic        done_next;

  logic [15:0] sample;
  logic [4:0]  weight;
  logic [2:0]  cls;
  logic [10:0] count_inc;
  logic [5:0]  step_coarse;
  logic [6:0]  step_fine;
  op_t         op;

  // pick the half word and classify it
  always_comb begin
    sample = (sensor_index[0] ? item.sensor_pair_word[31:16]
                              : item.sensor_pair_word[15:0]) & SAMPLE_MASK;
    weight = 5'($countones(sample));
    if (sample == 16'h0000) begin
      cls = CLS_ZEROS;
    end else if (weight == 5'(SAMPLE_BITS)) begin
      cls = CLS_ONES;
    end else if (!sample[0] && ((sample & SAMPLE_MSB) != 16'h0000)) begin
      cls = CLS_RISING;
    end else if (sample[0] && ((sample & SAMPLE_MSB) == 16'h0000)) begin
      cls = CLS_FALLING;
    end else begin
      cls = CLS_ERROR;
    end
    count_inc = (sample != 16'h0000 && nonzero_count < COUNT_MAX) ?
                nonzero_count + 11'd1 : nonzero_count;
  end

  // one step of the delay, fine first, saturating at the top
  always_comb begin
    step_coarse = coarse;
    step_fine   = fine;
    if (fine < FINE_MAX) begin
      step_fine = fine + 7'd1;
    end else if (coarse < COARSE_MAX) begin
      step_fine   = 7'd0;
      step_coarse = coarse + 6'd1;
    end
  end

  // next state and command for this item
  always_comb begin
    coarse_next = coarse;
    fine_next   = fine;
    count_next  = nonzero_count;
    locked_next = locked;
    done_next   = done;
    op          = OP_STATUS;
    if (item.func == FUNC_SAMPLE) begin
      if (!item.last_sample) begin
        count_next = count_inc;
        op         = OP_CLASS;
      end else begin
        count_next = 11'd0;
        if (!done && !locked && count_inc == 11'd0) begin
          coarse_next = step_coarse;
          fine_next   = step_fine;
          op          = OP_CLASS_WORDS;
        end else begin
          if (!done && count_inc != 11'd0) begin
            locked_next = 1'b1;
          end
          op = OP_CLASS_STATUS;
        end
      end
    end else begin
      if (!locked || done) begin
        op = OP_STATUS;
      end else if (item.accept) begin
        done_next = 1'b1;
        op        = OP_STATUS;
      end else begin
        coarse_next = step_coarse;
        fine_next   = step_fine;
        op          = OP_WORDS;
      end
    end
  end

  // command carries the state as it stands after the item
  always_comb begin
    cmd.op            = op;
    cmd.sample_class  = cls;
    cmd.sample_weight = weight;
    cmd.coarse_delay  = coarse_next;
    cmd.fine_delay    = fine_next;
    cmd.found         = locked_next && !done_next;
    cmd.exhausted     = (coarse_next >= COARSE_MAX) && (fine_next >= FINE_MAX);
    cmd.calibrated    = done_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_index  <= 5'd0;
      coarse        <= 6'd0;
      fine          <= 7'd0;
      nonzero_count <= 11'd0;
      locked        <= 1'b0;
      done          <= 1'b0;
    end else begin
      if (cfg_we) begin
        sensor_index <= cfg_data;
      end
      if (take) begin
        coarse        <= coarse_next;
        fine          <= fine_next;
        nonzero_count <= count_next;
        locked        <= locked_next;
        done          <= done_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dlsc_queue.sv
// ---------------------------------------------------------------------------
// dlsc_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module dlsc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire dlsc_pkg::cmd_t wr_cmd,
  input  wire logic           rd_en,
  output dlsc_pkg::cmd_t      head,
  output logic                q_full,
  output logic                q_valid
);
  import dlsc_pkg::*;

  cmd_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    fill;

  assign head    = entries[rd_ptr];
  assign q_full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (!wr_en && rd_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dlsc_back.sv
// ---------------------------------------------------------------------------
// dlsc_back
// Expands each queued command into its result words, one a cycle while the
// receiver pops, into an output register read as a queue.
// ---------------------------------------------------------------------------
`default_nettype none

module dlsc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dlsc_pkg::cmd_t head,
  input  wire logic           q_valid,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output dlsc_pkg::out_word_t result
);
  import dlsc_pkg::*;

  logic [2:0] step;
  logic       out_valid;
  logic       load;
  logic       is_last;
  logic [1:0] kind;
  logic [1:0] chunk;
  out_word_t  word_next;

  assign load  = q_valid && (!out_valid || pop);
  assign q_pop = load && is_last;
  assign empty = !out_valid;

  // kind and chunk of the word at this step of the command
  always_comb begin
    kind    = KIND_STATUS;
    chunk   = 2'd0;
    is_last = 1'b1;
    case (head.op)
      OP_CLASS: begin
        kind = KIND_CLASS;
      end
      OP_CLASS_WORDS: begin
        kind    = (step == 3'd0) ? KIND_CLASS : KIND_WORD;
        chunk   = 2'(step - 3'd1);
        is_last = (step == 3'(NUM_WORDS));
      end
      OP_CLASS_STATUS: begin
        kind    = (step == 3'd0) ? KIND_CLASS : KIND_STATUS;
        is_last = (step == 3'd1);
      end
      OP_STATUS: begin
        kind = KIND_STATUS;
      end
      OP_WORDS: begin
        kind    = KIND_WORD;
        chunk   = step[1:0];
        is_last = (step == 3'(NUM_WORDS - 1));
      end
      default: begin
        kind = KIND_STATUS;
      end
    endcase
  end

  // assemble the word
  always_comb begin
    word_next.kind          = kind;
    word_next.sample_class  = (kind == KIND_CLASS) ? head.sample_class : CLS_ZEROS;
    word_next.sample_weight = (kind == KIND_CLASS) ? head.sample_weight : 5'd0;
    word_next.delay_word    = (kind == KIND_WORD) ?
                              delay_chunk(head.coarse_delay, head.fine_delay, chunk) :
                              32'h0000_0000;
    word_next.word_index    = (kind == KIND_WORD) ? chunk : 2'd0;
    word_next.coarse_delay  = head.coarse_delay;
    word_next.fine_delay    = head.fine_delay;
    word_next.found         = head.found;
    word_next.exhausted     = head.exhausted;
    word_next.calibrated    = head.calibrated;
    word_next.last          = is_last;
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      result <= word_next;
    end
  end

  // step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step <= is_last ? 3'd0 : step + 3'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dlsc_checker.sv
// ---------------------------------------------------------------------------
// dlsc_checker
// Port-level checks on the calibrator's result stream.
// ---------------------------------------------------------------------------
`default_nettype none

module dlsc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                empty,
  input wire logic                pop,
  input wire dlsc_pkg::out_word_t result
);
  import dlsc_pkg::*;

  // nothing waits right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    disable iff (rst) $past(rst) |-> empty)
    else $error("result waiting right after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk)
    disable iff (rst) (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result word changed");

  // only defined kinds come out
  a_kind: assert property (@(posedge clk)
    disable iff (rst) !empty |-> (result.kind != 2'd3))
    else $error("undefined result kind");

  // delay words carry no classification
  a_word_clean: assert property (@(posedge clk)
    disable iff (rst) (!empty && result.kind == KIND_WORD) |->
      (result.sample_class == CLS_ZEROS && result.sample_weight == 5'd0))
    else $error("delay word with classification fields set");

  // exhausted only at both maxima
  a_exhausted: assert property (@(posedge clk)
    disable iff (rst) (!empty && result.exhausted) |->
      (result.coarse_delay == COARSE_MAX && result.fine_delay == FINE_MAX))
    else $error("exhausted flagged below maximum delay");

endmodule

bind delay_line_sensor_calibrator dlsc_checker u_dlsc_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire

### tb/sv/tb_delay_line_sensor_calibrator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_delay_line_sensor_calibrator
// Self-checking bench for the delay-line sensor calibrator. A clocked driver
// feeds trace samples and operator verdicts from a pending queue, a clocked
// monitor mirrors the calibration state at each accepted word and checks
// every result word field by field. Phases vary the sensor index and the
// idling on both sides. Phases cover a long hit trace, a reject sweep across
// the fine delay wrap into the coarse delay and a final accept.
// ---------------------------------------------------------------------------

module tb_delay_line_sensor_calibrator;
  import dlsc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic       push = 1'b0;
  logic       full;
  in_word_t   item = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_word_t  result;

  // pending input words and result words still owed by the block
  in_word_t  stim_items[$];
  out_word_t result_words_due[$];

  // mirrored calibration state
  logic [5:0]  cal_coarse = '0;
  logic [6:0]  cal_fine = '0;
  logic [10:0] nonzero_seen = '0;
  logic        cal_locked = 1'b0;
  logic        cal_done = 1'b0;
  logic [4:0]  sensor_sel = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int words_checked = 0;
  int cycle_count = 0;
  logic took_item = 1'b0;

  delay_line_sensor_calibrator u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at word %0d: %s got %0h want %0h", words_checked, what, got, want);
  endtask

  // word with the status after the current item
  function automatic out_word_t new_word(input logic [1:0] kind, input logic last_flag);
    out_word_t w;
    w = '0;
    w.kind = kind;
    w.coarse_delay = cal_coarse;
    w.fine_delay = cal_fine;
    w.found = cal_locked && !cal_done;
    w.exhausted = (cal_coarse >= COARSE_MAX) && (cal_fine >= FINE_MAX);
    w.calibrated = cal_done;
    w.last = last_flag;
    return w;
  endfunction

  // thermometer chunk, chunk 0 is the top (coarse) word, each filled from msb
  function automatic logic [31:0] therm_chunk(input int chunk);
    logic [31:0] w;
    int seg;
    int val;
    int pos;
    seg = NUM_WORDS - 1 - chunk;
    val = (seg < FINE_WORDS) ? int'(cal_fine) : int'(cal_coarse);
    if (seg >= FINE_WORDS) begin
      seg = seg - FINE_WORDS;
    end
    for (int b = 0; b < 32; b++) begin
      pos = 32 * seg + 31 - b;
      w[b] = (pos < val);
    end
    return w;
  endfunction

  task automatic step_delays();
    if (cal_fine < FINE_MAX) begin
      cal_fine++;
    end else if (cal_coarse < COARSE_MAX) begin
      cal_fine = '0;
      cal_coarse++;
    end
  endtask

  task automatic queue_delay_words();
    out_word_t w;
    for (int c = 0; c < NUM_WORDS; c++) begin
      w = new_word(KIND_WORD, c == NUM_WORDS - 1);
      w.delay_word = therm_chunk(c);
      w.word_index = 2'(c);
      result_words_due.push_back(w);
    end
  endtask

  // advance the calibration mirror by one accepted word
  task automatic advance_calibration(input in_word_t it);
    logic [15:0] s;
    out_word_t cw;
    bit hit;
    bit stepped;
    stepped = 0;
    if (it.func == FUNC_SAMPLE) begin
      s = sensor_sel[0] ? it.sensor_pair_word[31:16] : it.sensor_pair_word[15:0];
      s = s & SAMPLE_MASK;
      if (s != 0 && nonzero_seen != COUNT_MAX) begin
        nonzero_seen++;
      end
      if (it.last_sample) begin
        hit = (nonzero_seen != 0);
        nonzero_seen = '0;
        if (!cal_done && !cal_locked && !hit) begin
          step_delays();
          stepped = 1;
        end else if (!cal_done && hit) begin
          cal_locked = 1'b1;
        end
      end
      cw = new_word(KIND_CLASS, !it.last_sample);
      if (s == 0) begin
        cw.sample_class = CLS_ZEROS;
      end else if ($countones(s) == SAMPLE_BITS) begin
        cw.sample_class = CLS_ONES;
      end else if (!s[0] && s[SAMPLE_BITS-1]) begin
        cw.sample_class = CLS_RISING;
      end else if (s[0] && !s[SAMPLE_BITS-1]) begin
        cw.sample_class = CLS_FALLING;
      end else begin
        cw.sample_class = CLS_ERROR;
      end
      cw.sample_weight = 5'($countones(s));
      result_words_due.push_back(cw);
      if (stepped) begin
        queue_delay_words();
      end else if (it.last_sample) begin
        result_words_due.push_back(new_word(KIND_STATUS, 1'b1));
      end
    end else if (!cal_locked || cal_done) begin
      result_words_due.push_back(new_word(KIND_STATUS, 1'b1));
    end else if (it.accept) begin
      cal_done = 1'b1;
      result_words_due.push_back(new_word(KIND_STATUS, 1'b1));
    end else begin
      step_delays();
      queue_delay_words();
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (result_words_due.size() == 0) begin
      note_mismatch("word with nothing expected, kind", 32'(got.kind), '0);
    end else begin
      want = result_words_due.pop_front();
      if (got.kind !== want.kind) note_mismatch("kind", 32'(got.kind), 32'(want.kind));
      if (got.sample_class !== want.sample_class)
        note_mismatch("sample_class", 32'(got.sample_class), 32'(want.sample_class));
      if (got.sample_weight !== want.sample_weight)
        note_mismatch("sample_weight", 32'(got.sample_weight), 32'(want.sample_weight));
      if (got.delay_word !== want.delay_word)
        note_mismatch("delay_word", got.delay_word, want.delay_word);
      if (got.word_index !== want.word_index)
        note_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
      if (got.coarse_delay !== want.coarse_delay)
        note_mismatch("coarse_delay", 32'(got.coarse_delay), 32'(want.coarse_delay));
      if (got.fine_delay !== want.fine_delay)
        note_mismatch("fine_delay", 32'(got.fine_delay), 32'(want.fine_delay));
      if (got.found !== want.found) note_mismatch("found", 32'(got.found), 32'(want.found));
      if (got.exhausted !== want.exhausted)
        note_mismatch("exhausted", 32'(got.exhausted), 32'(want.exhausted));
      if (got.calibrated !== want.calibrated)
        note_mismatch("calibrated", 32'(got.calibrated), 32'(want.calibrated));
      if (got.last !== want.last) note_mismatch("last", 32'(got.last), 32'(want.last));
    end
    words_checked++;
  endtask

  // driver: a word is held until accepted, then the next one or an idle gap
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || took_item) begin
      if (stim_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item <= stim_items.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    if (rst) begin
      took_item <= 1'b0;
    end else begin
      took_item <= push && !full;
      if (push && !full) begin
        advance_calibration(item);
      end
      if (pop && !empty) begin
        check_word(result);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_word_t sample_item(input logic [15:0] s, input logic end_flag);
    in_word_t it;
    it.func = FUNC_SAMPLE;
    it.sensor_pair_word = $urandom;
    if (sensor_sel[0]) begin
      it.sensor_pair_word[31:16] = s;
    end else begin
      it.sensor_pair_word[15:0] = s;
    end
    it.last_sample = end_flag;
    it.accept = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic in_word_t verdict_item(input logic acc);
    in_word_t it;
    it.func = FUNC_VERDICT;
    it.sensor_pair_word = $urandom;
    it.last_sample = 1'($urandom_range(1));
    it.accept = acc;
    return it;
  endfunction

  // sample biased toward each class
  function automatic logic [15:0] rand_sample(input bit nonzero);
    logic [15:0] s;
    case ($urandom_range(6))
      0: s = 16'h0000;
      1: s = 16'hffff;
      2: s = {1'b1, 15'($urandom)} & 16'hfffe;
      3: s = {1'b0, 15'($urandom)} | 16'h0001;
      4: s = {1'b1, 15'($urandom)} | 16'h0001;
      default: s = 16'($urandom);
    endcase
    if (nonzero && s == 0) begin
      s = 16'h8000 >> $urandom_range(15);
    end
    return s;
  endfunction

  task automatic add_trace(input int len, input bit zero_only);
    for (int i = 0; i < len; i++) begin
      stim_items.push_back(sample_item(zero_only ? 16'h0000 : rand_sample(0), i == len - 1));
    end
  endtask

  task automatic write_sensor(input logic [4:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    sensor_sel = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until every owed word has come back, plus pipeline margin
  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (stim_items.size() != 0 || push || result_words_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int n;
    int steps_left;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unlocked start: ignored verdicts and empty traces that step the delays
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_sensor(5'd0);
    stim_items.push_back(verdict_item(1'b1));
    stim_items.push_back(verdict_item(1'b0));
    stim_items.push_back(sample_item(16'h0000, 1'b1));
    add_trace(2, 1);
    add_trace(3, 1);
    wait_idle();

    // more stepping traces on the upper half, sender gaps
    send_idle_pct = 47;
    write_sensor(5'd31);
    n = 0;
    while (n < 40) begin
      if ($urandom_range(4) == 0) begin
        stim_items.push_back(verdict_item(1'($urandom_range(1))));
        n++;
      end else begin
        add_trace($urandom_range(1, 4), 1);
        n = stim_items.size();
      end
    end
    wait_idle();

    // one long trace with every class, then the hit locks
    send_idle_pct = 0;
    recv_stall_pct = 47;
    write_sensor(5'(2 * $urandom_range(15)));
    stim_items.push_back(sample_item(16'hffff, 1'b0));
    stim_items.push_back(sample_item(16'h8000, 1'b0));
    stim_items.push_back(sample_item(16'h0001, 1'b0));
    stim_items.push_back(sample_item(16'h8001, 1'b0));
    stim_items.push_back(sample_item(16'h7ffe, 1'b0));
    stim_items.push_back(sample_item(16'h0000, 1'b0));
    for (int i = 0; i < 24; i++) begin
      stim_items.push_back(sample_item(rand_sample($urandom_range(9) != 0), 1'b0));
    end
    stim_items.push_back(sample_item(rand_sample(1), 1'b1));
    // locked: empty trace gives class and status words without a step, reject steps, hit trace waits
    add_trace(2, 1);
    stim_items.push_back(verdict_item(1'b0));
    stim_items.push_back(sample_item(16'h0001, 1'b1));
    wait_idle();

    // random traces and rejects while locked, both sides idling
    send_idle_pct = 32;
    recv_stall_pct = 32;
    write_sensor(5'(2 * $urandom_range(15) + 1));
    while (stim_items.size() < 190) begin
      if ($urandom_range(9) < 6) begin
        add_trace($urandom_range(1, 6), $urandom_range(3) == 0);
      end else begin
        stim_items.push_back(verdict_item(1'b0));
      end
    end
    wait_idle();

    // reject sweep across the fine delay wrap into the coarse delay
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_sensor(5'($urandom_range(31)));
    steps_left = (FINE_BITS + 1 - int'(cal_fine)) + 3;
    if (steps_left > 60) begin
      steps_left = 60;
    end
    for (int i = 0; i < steps_left; i++) begin
      stim_items.push_back(verdict_item(1'b0));
    end
    add_trace(2, 1);
    wait_idle();

    // mixed traffic with accepts, then traffic after calibration is done
    send_idle_pct = 47;
    write_sensor(5'd0);
    while (stim_items.size() < 50) begin
      if ($urandom_range(1) == 0) begin
        add_trace($urandom_range(1, 5), $urandom_range(3) == 0);
      end else begin
        stim_items.push_back(verdict_item($urandom_range(2) == 0));
      end
    end
    stim_items.push_back(verdict_item(1'b1));
    add_trace(3, 0);
    add_trace(2, 1);
    stim_items.push_back(verdict_item(1'b0));
    wait_idle();

    repeat (10) @(posedge clk);
    if (result_words_due.size() != 0) begin
      note_mismatch("words never delivered", 32'(result_words_due.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
